// ----- design/dsep_pkg.sv -----
// ----------------------------------------------------------------------------
// dsep_pkg: shared types and constants of the d-separation checker
// Node counts, command codes, datapath operation codes and the control and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsep_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = 5;
    localparam int CMD_W     = 3;
    localparam int SET_W     = 16;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_ADD_DIR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_DIR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_CONF = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_CONF = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

    typedef logic [MAX_NODES-1:0] row_t;
    typedef logic [NODE_W-1:0]    node_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,
        OP_COND,
        OP_MARG
    } op_t;

    typedef struct packed {
        op_t              op;
        node_t            e;
        node_t            x;
        node_t            y;
        row_t             jset;
        logic             edit_en;
        logic [CMD_W-1:0] edit_cmd;
        node_t            edit_from;
        node_t            edit_to;
    } dp_cmd_t;

    typedef struct packed {
        logic linked;
    } dp_stat_t;

    // Map a node set onto the node rows
    function automatic row_t set_to_row(input logic [SET_W-1:0] s);
        row_t r;
        r = '0;
        for (int k = 0; k < MAX_NODES; k++) begin
            if (k < SET_W) begin
                r[k] = s[k % SET_W];
            end
        end
        return r;
    endfunction

endpackage

// ----- design/dsep_if.sv -----
// ----------------------------------------------------------------------------
// dsep_if: channel interfaces of the d-separation checker
// Item input channel, result channel and node-count write channel.
// ----------------------------------------------------------------------------
interface dsep_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [4:0]  from_node;
    logic [4:0]  to_node;
    logic [15:0] source_set;
    logic [15:0] target_set;
    logic [15:0] cond_set;
    logic [15:0] interv_set;

    modport source (output valid, command, from_node, to_node, source_set,
                    target_set, cond_set, interv_set, input ready);
    modport sink   (input valid, command, from_node, to_node, source_set,
                    target_set, cond_set, interv_set, output ready);
endinterface

interface dsep_result_if;
    logic valid;
    logic ready;
    logic separated;

    modport source (output valid, separated, input ready);
    modport sink   (input valid, separated, output ready);
endinterface

interface dsep_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] num_nodes;

    modport source (output valid, num_nodes, input ready);
    modport sink   (input valid, num_nodes, output ready);
endinterface

// ----- design/dsep_datapath.sv -----
// ----------------------------------------------------------------------------
// dsep_datapath: edge matrices and working matrices
// Holds the directed and confounder matrices, applies edits, and applies one
// load, conditioning or marginalization step over the whole working set.
// ----------------------------------------------------------------------------
module dsep_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  dsep_pkg::dp_cmd_t cmd,
    output dsep_pkg::dp_stat_t stat
);
    import dsep_pkg::*;

    row_t dir_reg  [MAX_NODES];
    row_t conf_reg [MAX_NODES];
    row_t hh_reg   [MAX_NODES];
    row_t th_reg   [MAX_NODES];
    row_t tt_reg   [MAX_NODES];
    row_t hh_next  [MAX_NODES];
    row_t th_next  [MAX_NODES];
    row_t tt_next  [MAX_NODES];

    row_t hh_erow;
    row_t th_erow;
    row_t tt_erow;
    logic loop_e;

    // Row of the eliminated node and its self loop
    assign hh_erow = hh_reg[cmd.e];
    assign th_erow = th_reg[cmd.e];
    assign tt_erow = tt_reg[cmd.e];
    assign loop_e  = tt_erow[cmd.e];

    // Compute one step over all cells
    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++) begin
            hh_next[i] = hh_reg[i];
            th_next[i] = th_reg[i];
            tt_next[i] = tt_reg[i];
            for (int j = 0; j < MAX_NODES; j++) begin
                case (cmd.op)
                    OP_LOAD:
                    begin
                        hh_next[i][j] = conf_reg[i][j] & ~cmd.jset[j];
                        th_next[i][j] = dir_reg[i][j] & ~cmd.jset[j];
                        tt_next[i][j] = 1'b0;
                    end
                    OP_COND:
                    begin
                        hh_next[i][j] = hh_reg[i][j] | (hh_reg[i][cmd.e] & hh_erow[j]);
                        th_next[i][j] = th_reg[i][j] | (th_reg[i][cmd.e] & hh_erow[j]);
                        tt_next[i][j] = tt_reg[i][j] |
                                        (th_reg[i][cmd.e] & th_reg[j][cmd.e]);
                    end
                    OP_MARG:
                    begin
                        if (NODE_W'(i) != cmd.e && NODE_W'(j) != cmd.e) begin
                            hh_next[i][j] = hh_reg[i][j] |
                                (th_erow[i] & th_erow[j]) |
                                (hh_reg[i][cmd.e] & th_erow[j]) |
                                (th_erow[i] & hh_erow[j]) |
                                (hh_erow[i] & hh_erow[j] & loop_e);
                            tt_next[i][j] = tt_reg[i][j] |
                                (tt_reg[i][cmd.e] & tt_erow[j]) |
                                (th_reg[i][cmd.e] & tt_erow[j]) |
                                (tt_reg[i][cmd.e] & th_reg[j][cmd.e]) |
                                (th_reg[i][cmd.e] & th_reg[j][cmd.e] & loop_e);
                            th_next[i][j] = th_reg[i][j] |
                                (tt_reg[i][cmd.e] & th_erow[j]) |
                                (th_reg[i][cmd.e] & th_erow[j]) |
                                (tt_reg[i][cmd.e] & hh_erow[j]) |
                                (th_reg[i][cmd.e] & hh_erow[j] & loop_e);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Report a link between the pair in any matrix
    assign stat.linked = hh_reg[cmd.x][cmd.y] | hh_reg[cmd.y][cmd.x] |
                         th_reg[cmd.x][cmd.y] | th_reg[cmd.y][cmd.x] |
                         tt_reg[cmd.x][cmd.y] | tt_reg[cmd.y][cmd.x];

    // Hold edge matrices, apply edits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                dir_reg[i]  <= '0;
                conf_reg[i] <= '0;
            end
        end else if (cmd.edit_en) begin
            case (cmd.edit_cmd)
                CMD_ADD_DIR:  dir_reg[cmd.edit_from][cmd.edit_to] <= 1'b1;
                CMD_DEL_DIR:  dir_reg[cmd.edit_from][cmd.edit_to] <= 1'b0;
                CMD_ADD_CONF:
                begin
                    conf_reg[cmd.edit_from][cmd.edit_to] <= 1'b1;
                    conf_reg[cmd.edit_to][cmd.edit_from] <= 1'b1;
                end
                CMD_DEL_CONF:
                begin
                    conf_reg[cmd.edit_from][cmd.edit_to] <= 1'b0;
                    conf_reg[cmd.edit_to][cmd.edit_from] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Advance working matrices
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_NODES; i++) begin
            hh_reg[i] <= hh_next[i];
            th_reg[i] <= th_next[i];
            tt_reg[i] <= tt_next[i];
        end
    end

endmodule

// ----- design/dsep_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsep_ctrl: query sequencer of the d-separation checker
// Accepts items, walks source/target pairs and the eliminated node for each
// step, and holds the result register and the node count.
// ----------------------------------------------------------------------------
module dsep_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    dsep_item_if.sink          item_in,
    dsep_result_if.source      result_out,
    dsep_cfg_if.sink           cfg,
    output dsep_pkg::dp_cmd_t  cmd,
    input  dsep_pkg::dp_stat_t stat
);
    import dsep_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAIR,
        S_LOAD,
        S_CHK,
        S_COND,
        S_MARG,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_COND,
        PH_MARG,
        PH_END
    } phase_t;

    state_t           state_reg, state_next;
    phase_t           ph_reg, ph_next;
    node_t            x_reg, x_next;
    node_t            y_reg, y_next;
    node_t            e_reg, e_next;
    row_t             sset_reg, sset_next;
    row_t             tset_reg, tset_next;
    row_t             cset_reg, cset_next;
    row_t             jset_reg, jset_next;
    logic             sep_reg, sep_next;
    logic             out_valid_reg, out_valid_next;
    logic             res_reg, res_next;
    logic [CNT_W-1:0] n_reg, n_next;

    row_t             all_row;
    node_t            last;
    logic             accept;
    logic             edit_ok;
    logic             mbit;

    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++) begin
            all_row[k] = (CNT_W'(k) < n_reg);
        end
    end

    assign last    = NODE_W'(n_reg - CNT_W'(1));
    assign accept  = item_in.valid & item_in.ready;
    assign edit_ok = (item_in.from_node != '0) && (item_in.to_node != '0) &&
                     (item_in.from_node <= CNT_W'(MAX_NODES)) &&
                     (item_in.to_node <= CNT_W'(MAX_NODES));
    assign mbit    = ~cset_reg[e_reg] && (e_reg != x_reg) && (e_reg != y_reg);

    assign item_in.ready    = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign result_out.valid = out_valid_reg;
    assign result_out.separated = res_reg;

    // Drive datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.e         = e_reg;
        cmd.x         = x_reg;
        cmd.y         = y_reg;
        cmd.jset      = jset_reg;
        cmd.edit_en   = accept && (item_in.command <= CMD_DEL_CONF) && edit_ok;
        cmd.edit_cmd  = item_in.command;
        cmd.edit_from = NODE_W'(item_in.from_node - CNT_W'(1));
        cmd.edit_to   = NODE_W'(item_in.to_node - CNT_W'(1));
        case (state_reg)
            S_LOAD:  cmd.op = OP_LOAD;
            S_COND:  cmd.op = cset_reg[e_reg] ? OP_COND : OP_NOP;
            S_MARG:  cmd.op = mbit ? OP_MARG : OP_NOP;
            default: cmd.op = OP_NOP;
        endcase
    end

    // Sequence pairs and steps
    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        e_next         = e_reg;
        sset_next      = sset_reg;
        tset_next      = tset_reg;
        cset_next      = cset_reg;
        jset_next      = jset_reg;
        sep_next       = sep_reg;
        res_next       = res_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg & ~result_out.ready;

        // Clamp node count writes
        if (cfg.valid) begin
            if (cfg.num_nodes == '0) begin
                n_next = CNT_W'(1);
            end else if (cfg.num_nodes > CNT_W'(MAX_NODES)) begin
                n_next = CNT_W'(MAX_NODES);
            end else begin
                n_next = cfg.num_nodes;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && item_in.command == CMD_QUERY) begin
                    sset_next  = set_to_row(item_in.source_set) & all_row;
                    tset_next  = set_to_row(item_in.target_set) & all_row;
                    cset_next  = set_to_row(item_in.cond_set) & all_row;
                    jset_next  = set_to_row(item_in.interv_set) & all_row;
                    x_next     = '0;
                    y_next     = '0;
                    sep_next   = 1'b1;
                    state_next = S_PAIR;
                end
            end
            S_PAIR:
            begin
                if (sset_reg[x_reg] && tset_reg[y_reg]) begin
                    state_next = S_LOAD;
                end else if (y_reg == last) begin
                    y_next = '0;
                    if (x_reg == last) begin
                        state_next = S_FIN;
                    end else begin
                        x_next = x_reg + NODE_W'(1);
                    end
                end else begin
                    y_next = y_reg + NODE_W'(1);
                end
            end
            S_LOAD:
            begin
                e_next     = '0;
                ph_next    = PH_COND;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.linked) begin
                    sep_next   = 1'b0;
                    state_next = S_FIN;
                end else begin
                    case (ph_reg)
                        PH_COND: state_next = S_COND;
                        PH_MARG: state_next = S_MARG;
                        default:
                        begin
                            // Pair separated: advance to the next pair
                            if (y_reg == last) begin
                                y_next = '0;
                                if (x_reg == last) begin
                                    state_next = S_FIN;
                                end else begin
                                    x_next     = x_reg + NODE_W'(1);
                                    state_next = S_PAIR;
                                end
                            end else begin
                                y_next     = y_reg + NODE_W'(1);
                                state_next = S_PAIR;
                            end
                        end
                    endcase
                end
            end
            S_COND:
            begin
                if (e_reg == last) begin
                    e_next     = '0;
                    ph_next    = PH_MARG;
                    state_next = S_CHK;
                end else begin
                    e_next = e_reg + NODE_W'(1);
                    if (cset_reg[e_reg]) begin
                        state_next = S_CHK;
                    end
                end
            end
            S_MARG:
            begin
                if (e_reg == last) begin
                    e_next     = '0;
                    ph_next    = PH_END;
                    state_next = S_CHK;
                end else begin
                    e_next = e_reg + NODE_W'(1);
                    if (mbit) begin
                        state_next = S_CHK;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || result_out.ready) begin
                    out_valid_next = 1'b1;
                    res_next       = sep_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            ph_reg        <= PH_COND;
            out_valid_reg <= 1'b0;
            n_reg         <= CNT_W'(MAX_NODES);
        end else begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        e_reg    <= e_next;
        sset_reg <= sset_next;
        tset_reg <= tset_next;
        cset_reg <= cset_next;
        jset_reg <= jset_next;
        sep_reg  <= sep_next;
        res_reg  <= res_next;
    end

endmodule

// ----- design/dseparation_checker.sv -----
// Timing: edits take effect at the accept edge and give no result. A query walks
// the source/target pairs; each pair in both sets is loaded into the working
// matrices, then conditioned and marginalized node by node, with link checks
// between the steps, by the one-step-per-cycle matrix datapath.
// Throughput: one item at a time; edits are taken while a result waits.
// Reset: edge matrices cleared, node count 16, no result pending.
// ----------------------------------------------------------------------------
// dseparation_checker: d-separation test on a mixed graph
// Top level joining the query controller and the matrix datapath.
// ----------------------------------------------------------------------------
module dseparation_checker (
    input  logic          clk,
    input  logic          rst_n,
    dsep_item_if.sink     item_in,
    dsep_result_if.source result_out,
    dsep_cfg_if.sink      cfg
);
    import dsep_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dsep_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .cfg        (cfg),
        .cmd        (cmd),
        .stat       (stat)
    );

    dsep_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

// ----- test/dsep_scoreboard.sv -----
// ----------------------------------------------------------------------------
// dsep_scoreboard: result predictor and checker for the d-separation block
// Watches the item, result and node-count channels, keeps its own copy of the
// edge matrices and node count, works out the separation verdict of every
// accepted query and compares it with the results in order.
// ----------------------------------------------------------------------------
module dsep_scoreboard
    import dsep_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    dsep_item_if   item_ch,
    dsep_result_if res_ch,
    dsep_cfg_if    cfg_ch,
    output int     verdicts_waiting,
    output int     fail_cnt
);

    bit          dir_m  [MAX_NODES][MAX_NODES];
    bit          conf_m [MAX_NODES][MAX_NODES];
    bit          wk_hh  [MAX_NODES][MAX_NODES];
    bit          wk_th  [MAX_NODES][MAX_NODES];
    bit          wk_tt  [MAX_NODES][MAX_NODES];
    int unsigned node_cnt;
    bit          verdict_q[$];

    // True when the working matrices join a and b in either direction
    function automatic bit joined(int a, int b);
        return wk_hh[a][b] || wk_hh[b][a] || wk_th[a][b] || wk_th[b][a] ||
               wk_tt[a][b] || wk_tt[b][a];
    endfunction

    // Reduce the graph around one node pair; 1 means the pair is separated
    function automatic bit pair_is_separated(int n, int x, int y,
                                             logic [15:0] cs, logic [15:0] js);
        logic [15:0] ms;
        bit          lp;
        ms = 16'hFFFF;
        for (int k = 0; k < 16; k++)
        begin
            if (k >= n || cs[k] || k == x || k == y)
                ms[k] = 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                wk_hh[i][j] = conf_m[i][j];
                wk_tt[i][j] = 1'b0;
                wk_th[i][j] = dir_m[i][j];
            end
        end
        // Cut incoming edges of intervened nodes
        for (int e = 0; e < n; e++)
        begin
            if (js[e])
            begin
                for (int i = 0; i < n; i++)
                begin
                    wk_hh[i][e] = 1'b0;
                    wk_th[i][e] = 1'b0;
                end
            end
        end
        if (joined(x, y))
            return 1'b0;
        // Condition, in place and row-major
        for (int e = 0; e < n; e++)
        begin
            if (!cs[e])
                continue;
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    wk_hh[i][j] = wk_hh[i][j] || (wk_hh[i][e] && wk_hh[e][j]);
                    wk_th[i][j] = wk_th[i][j] || (wk_th[i][e] && wk_hh[e][j]);
                    wk_tt[i][j] = wk_tt[i][j] || (wk_th[i][e] && wk_th[j][e]);
                end
            end
            if (joined(x, y))
                return 1'b0;
        end
        // Marginalize the remaining nodes
        for (int e = 0; e < n; e++)
        begin
            if (!ms[e])
                continue;
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    if (i == e || j == e)
                        continue;
                    lp = wk_tt[e][e];
                    wk_hh[i][j] = wk_hh[i][j] || (wk_th[e][i] && wk_th[e][j]) ||
                                  (wk_hh[i][e] && wk_th[e][j]) ||
                                  (wk_th[e][i] && wk_hh[e][j]) ||
                                  (wk_hh[e][i] && wk_hh[e][j] && lp);
                    wk_tt[i][j] = wk_tt[i][j] || (wk_tt[i][e] && wk_tt[e][j]) ||
                                  (wk_th[i][e] && wk_tt[e][j]) ||
                                  (wk_tt[i][e] && wk_th[j][e]) ||
                                  (wk_th[i][e] && wk_th[j][e] && lp);
                    wk_th[i][j] = wk_th[i][j] || (wk_tt[i][e] && wk_th[e][j]) ||
                                  (wk_th[i][e] && wk_th[e][j]) ||
                                  (wk_tt[i][e] && wk_hh[e][j]) ||
                                  (wk_th[i][e] && wk_hh[e][j] && lp);
                end
            end
            if (joined(x, y))
                return 1'b0;
        end
        return !joined(x, y);
    endfunction

    // Apply one item to the edge store, or predict the verdict of a query
    function automatic void apply_item(logic [2:0] cmd, logic [4:0] fn, logic [4:0] tn,
                                       logic [15:0] ss, logic [15:0] ts,
                                       logic [15:0] cs, logic [15:0] js);
        int          n;
        logic [15:0] in_use;
        bit          sep;
        n = int'(node_cnt);
        in_use = (n == 16) ? 16'hFFFF : 16'((1 << n) - 1);
        if (cmd <= CMD_DEL_CONF)
        begin
            if (fn == 0 || tn == 0 || fn > MAX_NODES || tn > MAX_NODES)
                return;
            case (cmd)
                CMD_ADD_DIR: dir_m[fn-1][tn-1] = 1'b1;
                CMD_DEL_DIR: dir_m[fn-1][tn-1] = 1'b0;
                default:
                begin
                    conf_m[fn-1][tn-1] = (cmd == CMD_ADD_CONF);
                    conf_m[tn-1][fn-1] = (cmd == CMD_ADD_CONF);
                end
            endcase
        end
        else if (cmd == CMD_QUERY)
        begin
            ss &= in_use;
            ts &= in_use;
            cs &= in_use;
            js &= in_use;
            sep = 1'b1;
            for (int x = 0; x < n && sep; x++)
            begin
                if (!ss[x])
                    continue;
                for (int y = 0; y < n && sep; y++)
                begin
                    if (ts[y])
                        sep = pair_is_separated(n, x, y, cs, js);
                end
            end
            verdict_q.push_back(sep);
        end
    endfunction

    // Track channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                for (int j = 0; j < MAX_NODES; j++)
                begin
                    dir_m[i][j]  = 1'b0;
                    conf_m[i][j] = 1'b0;
                end
            end
            node_cnt = 16;
            verdict_q.delete();
            verdicts_waiting = 0;
            fail_cnt = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result separated=%0d", $time,
                             res_ch.separated);
                    fail_cnt++;
                end
                else if (verdict_q[0] !== res_ch.separated)
                begin
                    $display("%0t: separated expected %0d actual %0d", $time,
                             verdict_q[0], res_ch.separated);
                    fail_cnt++;
                    void'(verdict_q.pop_front());
                end
                else
                    void'(verdict_q.pop_front());
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                node_cnt = (cfg_ch.num_nodes == 0) ? 1 :
                           (cfg_ch.num_nodes > MAX_NODES) ? MAX_NODES : cfg_ch.num_nodes;
            end
            if (item_ch.valid && item_ch.ready)
                apply_item(item_ch.command, item_ch.from_node, item_ch.to_node,
                           item_ch.source_set, item_ch.target_set,
                           item_ch.cond_set, item_ch.interv_set);
            verdicts_waiting = verdict_q.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the d-separation checker
// Drives directed and random graph edits and queries over several node
// counts, with random idle bursts on both sides; the scoreboard predicts and
// checks every verdict, and the top gives the final verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import dsep_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   fail_cnt;
    int   verdicts_waiting;
    int   idle_cycles;

    dsep_item_if   item_ch ();
    dsep_result_if res_ch ();
    dsep_cfg_if    cfg_ch ();

    dseparation_checker i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (res_ch),
        .cfg        (cfg_ch)
    );

    dsep_scoreboard i_scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_ch          (item_ch),
        .res_ch           (res_ch),
        .cfg_ch           (cfg_ch),
        .verdicts_waiting (verdicts_waiting),
        .fail_cnt         (fail_cnt)
    );

    // Generate clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Insert a random idle burst unless in the quiet tail
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) @(negedge clk);
    endtask

    // Send one item and hold it until accepted
    task automatic send_item(logic [2:0] cmd, logic [4:0] fn, logic [4:0] tn,
                             logic [15:0] ss, logic [15:0] ts,
                             logic [15:0] cs, logic [15:0] js);
        maybe_idle();
        item_ch.command    = cmd;
        item_ch.from_node  = fn;
        item_ch.to_node    = tn;
        item_ch.source_set = ss;
        item_ch.target_set = ts;
        item_ch.cond_set   = cs;
        item_ch.interv_set = js;
        item_ch.valid      = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
        item_ch.valid = 1'b0;
    endtask

    // Drain all verdicts, let edits settle, then write the node count
    task automatic set_nodes(logic [4:0] val);
        wait (verdicts_waiting == 0);
        repeat (8) @(negedge clk);
        cfg_ch.num_nodes = val;
        cfg_ch.valid     = 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Random edits, queries and unused commands, with nodes mostly within n nodes
    task automatic random_phase(int n, int cnt);
        logic [2:0] cmd;
        logic [4:0] fn;
        logic [4:0] tn;
        int         pick;
        for (int k = 0; k < cnt; k++)
        begin
            pick = $urandom_range(0, 99);
            fn = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                 5'($urandom_range(1, n));
            tn = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                 5'($urandom_range(1, n));
            if (pick < 3)
                cmd = 3'($urandom_range(5, 7));
            else if (pick < 30)
                cmd = CMD_ADD_DIR;
            else if (pick < 40)
                cmd = CMD_DEL_DIR;
            else if (pick < 52)
                cmd = CMD_ADD_CONF;
            else if (pick < 58)
                cmd = CMD_DEL_CONF;
            else
                cmd = CMD_QUERY;
            send_item(cmd, fn, tn, 16'($urandom()), 16'($urandom()),
                      16'($urandom()) & 16'($urandom()), 16'($urandom()) & 16'($urandom()));
        end
    endtask

    // Stall the result side in random bursts
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            res_ch.ready = 1'b1;
        end
    end

    // Watch for a hang
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus and verdict
    initial
    begin
        quiet              = 1'b0;
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.command    = CMD_ADD_DIR;
        item_ch.from_node  = '0;
        item_ch.to_node    = '0;
        item_ch.source_set = '0;
        item_ch.target_set = '0;
        item_ch.cond_set   = '0;
        item_ch.interv_set = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.num_nodes   = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: chain, collider, confounders, odd sets, bad edits
        send_item(CMD_QUERY, 0, 0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_item(CMD_ADD_DIR, 1, 2, 0, 0, 0, 0);
        send_item(CMD_ADD_DIR, 2, 3, 0, 0, 0, 0);
        send_item(CMD_ADD_CONF, 3, 4, 0, 0, 0, 0);
        send_item(CMD_ADD_DIR, 5, 3, 0, 0, 0, 0);
        send_item(CMD_QUERY, 0, 0, 16'h0001, 16'h0008, 16'h0000, 16'h0000);
        send_item(CMD_QUERY, 0, 0, 16'h0001, 16'h0008, 16'h0002, 16'h0000);
        send_item(CMD_QUERY, 0, 0, 16'h0001, 16'h0010, 16'h0000, 16'h0000);
        send_item(CMD_QUERY, 0, 0, 16'h0001, 16'h0010, 16'h0004, 16'h0000);
        send_item(CMD_QUERY, 0, 0, 16'h0001, 16'h0008, 16'h0000, 16'h0004);
        send_item(CMD_QUERY, 0, 0, 16'h0000, 16'h0008, 16'h0000, 16'h0000);
        send_item(CMD_QUERY, 0, 0, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_QUERY, 0, 0, 16'h0004, 16'h0004, 16'h0000, 16'h0000);
        send_item(CMD_ADD_DIR, 0, 2, 0, 0, 0, 0);
        send_item(CMD_ADD_DIR, 16, 17, 0, 0, 0, 0);
        send_item(CMD_ADD_CONF, 31, 16, 0, 0, 0, 0);
        send_item(CMD_ADD_DIR, 16, 16, 0, 0, 0, 0);
        send_item(3'd5, 1, 1, 0, 0, 0, 0);
        send_item(3'd6, 2, 2, 0, 0, 0, 0);
        send_item(3'd7, 31, 31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_QUERY, 0, 0, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_item(CMD_DEL_DIR, 2, 3, 0, 0, 0, 0);
        send_item(CMD_DEL_CONF, 4, 3, 0, 0, 0, 0);
        send_item(CMD_QUERY, 0, 0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);

        // Other node counts, including out-of-range writes, with bits set beyond the nodes in use
        set_nodes(5'd4);
        send_item(CMD_QUERY, 0, 0, 16'hFFF1, 16'hFFF2, 16'hFFF0, 16'hFFF0);
        set_nodes(5'd0);
        random_phase(1, 8);
        set_nodes(5'd31);
        random_phase(16, 18);
        set_nodes(5'd3);
        random_phase(3, 20);
        set_nodes(5'd5);
        random_phase(5, 22);
        set_nodes(5'd2);
        random_phase(2, 12);
        set_nodes(5'd8);
        random_phase(8, 22);
        set_nodes(5'd6);
        quiet = 1'b1;
        random_phase(6, 20);

        wait (verdicts_waiting == 0);
        repeat (50) @(negedge clk);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
